FILE: sv/apcs_pkg.sv
// Package for the box pair collision block: sizes, box and result types,
// side codes and the contact side rules.
// No dependencies.
`default_nettype none

package apcs_pkg;

    // Capacity and field widths
    localparam int MAX_BOXES  = 8;
    localparam int IDX_W      = 3;
    localparam int CNT_W      = $clog2(MAX_BOXES + 1);
    localparam int POS_W      = 24;
    localparam int SIZE_W     = 23;
    localparam int EDGE_W     = POS_W + 1;
    localparam int OVL_W      = EDGE_W + 1;
    localparam int VEL_W      = 16;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 8;

    // Report queue between the pair pipeline and the output register
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        SIDE_NONE   = 3'd0,
        SIDE_LEFT   = 3'd1,
        SIDE_RIGHT  = 3'd2,
        SIDE_TOP    = 3'd3,
        SIDE_BOTTOM = 3'd4
    } t_side;

    // One stored box: edges precomputed at load time
    typedef struct packed {
        logic signed [VEL_W-1:0]  vy;
        logic signed [VEL_W-1:0]  vx;
        logic signed [EDGE_W-1:0] y1;
        logic signed [POS_W-1:0]  y0;
        logic signed [EDGE_W-1:0] x1;
        logic signed [POS_W-1:0]  x0;
    } t_box;

    // Velocity classification of one box
    typedef struct packed {
        logic vx_zero;
        logic vx_pos;
        logic vy_zero;
        logic vy_pos;
    } t_vflags;

    // Edge tests of the moving box against the other one
    typedef struct packed {
        logic lt_x0;
        logic gt_x1;
        logic lt_y0;
        logic gt_y1;
    } t_rej;

    // Outcome of one pair test
    typedef struct packed {
        logic             valid;
        logic             overlap;
        t_side            side_i;
        t_side            side_j;
        logic [IDX_W-1:0] idx_i;
        logic [IDX_W-1:0] idx_j;
    } t_pair_res;

    // One report entry
    typedef struct packed {
        t_side            side;
        logic [IDX_W-1:0] idx;
    } t_rpt;

    function automatic t_side opposite(input t_side s);
        t_side r;
        unique case (s)
            SIDE_LEFT:   r = SIDE_RIGHT;
            SIDE_RIGHT:  r = SIDE_LEFT;
            SIDE_TOP:    r = SIDE_BOTTOM;
            SIDE_BOTTOM: r = SIDE_TOP;
            default:     r = SIDE_NONE;
        endcase
        return r;
    endfunction

    // Side seen by a moving box, then reject sides that the edges contradict
    function automatic t_side moving_side(input t_vflags v, input logic cxgt, input t_rej rj);
        t_side r;
        r = SIDE_NONE;
        priority if (v.vy_zero) begin
            r = v.vx_pos ? SIDE_RIGHT : SIDE_LEFT;
        end else if (v.vx_zero || cxgt) begin
            r = v.vy_pos ? SIDE_BOTTOM : SIDE_TOP;
        end else begin
            r = v.vx_pos ? SIDE_RIGHT : SIDE_LEFT;
        end
        if ((r == SIDE_LEFT && rj.lt_x0) || (r == SIDE_RIGHT && rj.gt_x1) ||
            (r == SIDE_TOP && rj.lt_y0) || (r == SIDE_BOTTOM && rj.gt_y1)) begin
            r = SIDE_NONE;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/aabb_pair_collision_sides.sv
// Top level: box store memory, pair sequencer, report queue and output register.
// Depends on apcs_pkg and apcs_pair_eval.
//
//  Channel   Direction  tdata fields (low bit up)                          tlast
//  s_axis    in         box_left, box_top, box_width, box_height,          final_box
//                       velocity_x, velocity_y, zero pad to 128 bits
//  m_axis    out        box_index, contact_side, zero pad to 8 bits        end_of_report
//
// Boxes are accepted only in the load state. After the final box, one pair (i<j)
// is read from the two-port box memory per cycle unless the report queue stalls
// the pipeline, and tested in a four-stage pipeline; N boxes give N*(N-1)/2 pairs,
// then a drain and a scan of the N boxes for untouched ones. Each overlapping pair
// gives two reports, so a busy frame is limited by the output port. Stalls on
// m_axis back up through the report queue into the pair pipeline. Reset clears
// the control state only, not the box memory.
`default_nettype none

module aabb_pair_collision_sides
    import apcs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // left[23:0], top[47:24], width[70:48], height[93:71], vx[109:94], vy[125:110]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // box_index[2:0], contact_side[5:3]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast
);

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_PAIR  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_NONE  = 5'b01000,
        ST_FLUSH = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [IDX_W-1:0]     r_i, n_i, r_j, n_j, r_k, n_k;
    logic [MAX_BOXES-1:0] r_touched, n_touched;

    t_box                 mem [MAX_BOXES];
    t_box                 r_ra, r_rb;
    t_box                 w_box;
    logic                 r_p1_v;
    logic [IDX_W-1:0]     r_p1_i, r_p1_j;

    t_rpt                 r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_q_wr, r_q_rd;
    logic [Q_CNT_W-1:0]   r_q_cnt, n_q_cnt;

    t_rpt                 r_out;
    logic                 r_out_v, r_out_last;

    t_pair_res            w_res;
    logic                 w_busy;
    logic                 w_load, w_store, w_adv, w_issue, w_take, w_push2;
    logic                 w_scan_step, w_scan_push, w_out_free, w_pop;
    logic [CNT_W-1:0]     w_cnt_inc;
    logic signed [POS_W-1:0] w_left, w_top;
    logic [SIZE_W-1:0]    w_width, w_height;

    // Unpack the box request and precompute its far edges
    always_comb begin
        w_left   = s_axis_tdata[23:0];
        w_top    = s_axis_tdata[47:24];
        w_width  = s_axis_tdata[70:48];
        w_height = s_axis_tdata[93:71];
        w_box.x0 = w_left;
        w_box.y0 = w_top;
        w_box.x1 = $signed({w_left[POS_W-1], w_left}) + $signed({2'b00, w_width});
        w_box.y1 = $signed({w_top[POS_W-1], w_top}) + $signed({2'b00, w_height});
        w_box.vx = s_axis_tdata[109:94];
        w_box.vy = s_axis_tdata[125:110];
    end

    // Handshakes and pipeline advance
    always_comb begin
        s_axis_tready = (r_state == ST_LOAD);
        w_load        = s_axis_tvalid && s_axis_tready;
        w_store       = w_load && (r_cnt < CNT_W'(MAX_BOXES));
        w_cnt_inc     = w_store ? r_cnt + CNT_W'(1) : r_cnt;
        w_take        = w_res.valid && (r_q_cnt <= Q_CNT_W'(Q_DEPTH - 2));
        w_push2       = w_take && w_res.overlap;
        w_adv         = !w_res.valid || w_take;
        w_issue       = (r_state == ST_PAIR) && w_adv;
        w_scan_push   = (r_state == ST_NONE) && !r_touched[r_k] &&
                        (r_q_cnt < Q_CNT_W'(Q_DEPTH));
        w_scan_step   = (r_state == ST_NONE) &&
                        (r_touched[r_k] || (r_q_cnt < Q_CNT_W'(Q_DEPTH)));
        w_out_free    = !r_out_v || m_axis_tready;
        w_pop         = w_out_free && ((r_q_cnt >= Q_CNT_W'(2)) ||
                        ((r_q_cnt == Q_CNT_W'(1)) && (r_state == ST_FLUSH)));
    end

    // Queue occupancy
    always_comb begin
        n_q_cnt = r_q_cnt;
        if (w_push2) begin
            n_q_cnt = n_q_cnt + Q_CNT_W'(2);
        end
        if (w_scan_push) begin
            n_q_cnt = n_q_cnt + Q_CNT_W'(1);
        end
        if (w_pop) begin
            n_q_cnt = n_q_cnt - Q_CNT_W'(1);
        end
    end

    // Sequencer: load, pair issue, drain, untouched scan, flush
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_touched = r_touched;
        if (w_push2) begin
            n_touched[w_res.idx_i] = 1'b1;
            n_touched[w_res.idx_j] = 1'b1;
        end
        unique case (r_state)
            ST_LOAD: begin
                if (w_load) begin
                    n_cnt = w_cnt_inc;
                    if (s_axis_tlast) begin
                        n_touched = '0;
                        n_i       = '0;
                        n_j       = IDX_W'(1);
                        n_state   = (w_cnt_inc >= CNT_W'(2)) ? ST_PAIR : ST_DRAIN;
                    end
                end
            end
            ST_PAIR: begin
                if (w_issue) begin
                    if (CNT_W'(r_j) == r_cnt - CNT_W'(1)) begin
                        if (CNT_W'(r_i) == r_cnt - CNT_W'(2)) begin
                            n_state = ST_DRAIN;
                        end else begin
                            n_i = r_i + IDX_W'(1);
                            n_j = r_i + IDX_W'(2);
                        end
                    end else begin
                        n_j = r_j + IDX_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (!r_p1_v && !w_busy) begin
                    n_k     = '0;
                    n_state = ST_NONE;
                end
            end
            ST_NONE: begin
                if (w_scan_step) begin
                    if (CNT_W'(r_k) == r_cnt - CNT_W'(1)) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_k = r_k + IDX_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if ((r_q_cnt == '0) && w_out_free) begin
                    n_cnt   = '0;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_cnt     <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_touched <= '0;
            r_p1_v    <= 1'b0;
            r_q_wr    <= '0;
            r_q_rd    <= '0;
            r_q_cnt   <= '0;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_i       <= n_i;
            r_j       <= n_j;
            r_k       <= n_k;
            r_touched <= n_touched;
            r_q_cnt   <= n_q_cnt;
            if (w_adv) begin
                r_p1_v <= w_issue;
            end
            if (w_push2) begin
                r_q_wr <= r_q_wr + Q_PTR_W'(2);
            end else if (w_scan_push) begin
                r_q_wr <= r_q_wr + Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_q_rd  <= r_q_rd + Q_PTR_W'(1);
                r_out_v <= 1'b1;
            end else if (w_out_free) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Box memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            mem[r_cnt[IDX_W-1:0]] <= w_box;
        end
        if (w_adv) begin
            r_ra   <= mem[r_i];
            r_rb   <= mem[r_j];
            r_p1_i <= r_i;
            r_p1_j <= r_j;
        end
    end

    // Report queue entries and output register
    always_ff @(posedge i_clk) begin
        if (w_push2) begin
            r_q[r_q_wr]                  <= '{side: w_res.side_i, idx: w_res.idx_i};
            r_q[r_q_wr + Q_PTR_W'(1)]    <= '{side: w_res.side_j, idx: w_res.idx_j};
        end else if (w_scan_push) begin
            r_q[r_q_wr]                  <= '{side: SIDE_NONE, idx: r_k};
        end
        if (w_pop) begin
            r_out      <= r_q[r_q_rd];
            r_out_last <= (r_q_cnt == Q_CNT_W'(1));
        end
    end

    apcs_pair_eval u_pair_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_p1_v),
        .i_idx_a (r_p1_i),
        .i_idx_b (r_p1_j),
        .i_box_a (r_ra),
        .i_box_b (r_rb),
        .o_res   (w_res),
        .o_busy  (w_busy)
    );

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {2'b00, r_out.side, r_out.idx};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

FILE: sv/apcs_pair_eval.sv
// Three-stage pair test: edge compares, overlap extents, contact sides.
// Depends on apcs_pkg.
`default_nettype none

module apcs_pair_eval
    import apcs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic             i_valid,
    input  wire logic [IDX_W-1:0] i_idx_a,
    input  wire logic [IDX_W-1:0] i_idx_b,
    input  wire t_box             i_box_a,
    input  wire t_box             i_box_b,
    output t_pair_res             o_res,
    output logic                  o_busy
);

    // Stage 1 registers
    logic                     r_s1_v;
    logic [IDX_W-1:0]         r_s1_i, r_s1_j;
    logic signed [EDGE_W-1:0] r_mnx1, r_mny1;
    logic signed [POS_W-1:0]  r_mxx0, r_mxy0;
    t_rej                     r_s1_rej_a, r_s1_rej_b;
    t_vflags                  r_s1_fa, r_s1_fb;
    logic                     r_s1_flip;

    // Stage 2 registers
    logic                     r_s2_v;
    logic [IDX_W-1:0]         r_s2_i, r_s2_j;
    logic signed [OVL_W-1:0]  r_cx, r_cy;
    t_rej                     r_s2_rej_a, r_s2_rej_b;
    t_vflags                  r_s2_fa, r_s2_fb;
    logic                     r_s2_flip;

    // Stage 3 registers
    logic                     r_s3_v;
    logic                     r_s3_ov;
    t_side                    r_s3_si, r_s3_sj;
    logic [IDX_W-1:0]         r_s3_i, r_s3_j;

    t_rej                     w_rej_a, w_rej_b;
    t_vflags                  w_fa, w_fb;
    logic                     w_same, w_flip;
    logic signed [OVL_W-1:0]  w_cx, w_cy;
    logic                     w_ov, w_cxgt;
    t_side                    w_side;

    // Edge compares and velocity classes
    always_comb begin
        w_rej_a.lt_x0 = i_box_a.x0 < i_box_b.x0;
        w_rej_a.gt_x1 = i_box_a.x1 > i_box_b.x1;
        w_rej_a.lt_y0 = i_box_a.y0 < i_box_b.y0;
        w_rej_a.gt_y1 = i_box_a.y1 > i_box_b.y1;
        w_rej_b.lt_x0 = i_box_b.x0 < i_box_a.x0;
        w_rej_b.gt_x1 = i_box_b.x1 > i_box_a.x1;
        w_rej_b.lt_y0 = i_box_b.y0 < i_box_a.y0;
        w_rej_b.gt_y1 = i_box_b.y1 > i_box_a.y1;
        w_fa.vx_zero  = i_box_a.vx == '0;
        w_fa.vx_pos   = i_box_a.vx > 0;
        w_fa.vy_zero  = i_box_a.vy == '0;
        w_fa.vy_pos   = i_box_a.vy > 0;
        w_fb.vx_zero  = i_box_b.vx == '0;
        w_fb.vx_pos   = i_box_b.vx > 0;
        w_fb.vy_zero  = i_box_b.vy == '0;
        w_fb.vy_pos   = i_box_b.vy > 0;
        w_same        = (i_box_a.vx == i_box_b.vx) && (i_box_a.vy == i_box_b.vy);
        w_flip        = w_fa.vx_zero && w_fa.vy_zero && !w_same;
    end

    // Overlap extents, signed with one guard bit
    assign w_cx = $signed({r_mnx1[EDGE_W-1], r_mnx1}) -
                  $signed({{2{r_mxx0[POS_W-1]}}, r_mxx0});
    assign w_cy = $signed({r_mny1[EDGE_W-1], r_mny1}) -
                  $signed({{2{r_mxy0[POS_W-1]}}, r_mxy0});

    // Overlap test and side selection
    always_comb begin
        w_ov   = (r_cx > 0) && (r_cy > 0);
        w_cxgt = r_cx > r_cy;
        if (r_s2_flip) begin
            w_side = opposite(moving_side(r_s2_fb, w_cxgt, r_s2_rej_b));
        end else begin
            w_side = moving_side(r_s2_fa, w_cxgt, r_s2_rej_a);
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (i_adv) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    // Payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_i     <= i_idx_a;
            r_s1_j     <= i_idx_b;
            r_mnx1     <= w_rej_a.gt_x1 ? i_box_b.x1 : i_box_a.x1;
            r_mny1     <= w_rej_a.gt_y1 ? i_box_b.y1 : i_box_a.y1;
            r_mxx0     <= w_rej_a.lt_x0 ? i_box_b.x0 : i_box_a.x0;
            r_mxy0     <= w_rej_a.lt_y0 ? i_box_b.y0 : i_box_a.y0;
            r_s1_rej_a <= w_rej_a;
            r_s1_rej_b <= w_rej_b;
            r_s1_fa    <= w_fa;
            r_s1_fb    <= w_fb;
            r_s1_flip  <= w_flip;

            r_s2_i     <= r_s1_i;
            r_s2_j     <= r_s1_j;
            r_cx       <= w_cx;
            r_cy       <= w_cy;
            r_s2_rej_a <= r_s1_rej_a;
            r_s2_rej_b <= r_s1_rej_b;
            r_s2_fa    <= r_s1_fa;
            r_s2_fb    <= r_s1_fb;
            r_s2_flip  <= r_s1_flip;

            r_s3_i     <= r_s2_i;
            r_s3_j     <= r_s2_j;
            r_s3_ov    <= w_ov;
            r_s3_si    <= w_side;
            r_s3_sj    <= opposite(w_side);
        end
    end

    assign o_res.valid   = r_s3_v;
    assign o_res.overlap = r_s3_ov;
    assign o_res.side_i  = r_s3_si;
    assign o_res.side_j  = r_s3_sj;
    assign o_res.idx_i   = r_s3_i;
    assign o_res.idx_j   = r_s3_j;
    assign o_busy        = r_s1_v || r_s2_v || r_s3_v;

endmodule

`default_nettype wire

FILE: bench/aabb_pair_collision_sides_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for aabb_pair_collision_sides: streams frames of boxes in,
// predicts the contact-side report of every overlapping pair and of every untouched box, and checks them in order.
// Depends on apcs_pkg and the aabb_pair_collision_sides RTL.

module aabb_pair_collision_sides_tb
    import apcs_pkg::*;
();

    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 64;
    localparam int MAX_GAP      = 16;
    localparam int RANDOM_ITEMS = 386;

    // One box as it travels on s_axis_tdata (last member in the lowest bits)
    typedef struct packed {
        logic signed [VEL_W-1:0] vy;
        logic signed [VEL_W-1:0] vx;
        logic [SIZE_W-1:0]       height;
        logic [SIZE_W-1:0]       width;
        logic signed [POS_W-1:0] top;
        logic signed [POS_W-1:0] left;
    } t_box_fields;

    // One expected contact report
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        t_side            side;
        logic             last;
    } t_side_report;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // left, top, width, height, vx, vy, zero pad (low bit up)
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // box_index, contact_side, zero pad (low bit up)
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // Predictor state: boxes of the open frame and reports still owed
    t_box_fields  held_boxes [MAX_BOXES];
    int           boxes_held = 0;
    t_side_report pending_reports [$];

    int mismatch_count = 0;
    int boxes_sent     = 0;
    int sink_hold      = 0;
    int quiet_cycles   = 0;
    bit src_pace       = 1'b0;
    bit sink_pace      = 1'b0;

    aabb_pair_collision_sides uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Contact side prediction
    // ------------------------------------------------------------------
    function automatic longint right_edge(input t_box_fields b);
        return longint'(b.left) + longint'(b.width);
    endfunction

    function automatic longint bottom_edge(input t_box_fields b);
        return longint'(b.top) + longint'(b.height);
    endfunction

    // Length of the shared part of two intervals, zero or less when apart
    function automatic longint span_overlap(input longint a0, input longint a1,
                                            input longint b0, input longint b1);
        return ((a1 < b1) ? a1 : b1) - ((a0 > b0) ? a0 : b0);
    endfunction

    function automatic t_side reverse_side(input t_side s);
        unique case (s)
            SIDE_LEFT:   return SIDE_RIGHT;
            SIDE_RIGHT:  return SIDE_LEFT;
            SIDE_TOP:    return SIDE_BOTTOM;
            SIDE_BOTTOM: return SIDE_TOP;
            default:     return SIDE_NONE;
        endcase
    endfunction

    // Side that box a sees from its own motion, dropped when its edges disagree
    function automatic t_side mover_side(input t_box_fields a, input t_box_fields b);
        longint cx, cy;
        t_side  s;
        cx = span_overlap(a.left, right_edge(a), b.left, right_edge(b));
        cy = span_overlap(a.top, bottom_edge(a), b.top, bottom_edge(b));
        if (a.vy == 0) begin
            s = (a.vx > 0) ? SIDE_RIGHT : SIDE_LEFT;
        end else if (a.vx == 0 || cx > cy) begin
            s = (a.vy > 0) ? SIDE_BOTTOM : SIDE_TOP;
        end else begin
            s = (a.vx > 0) ? SIDE_RIGHT : SIDE_LEFT;
        end
        unique case (s)
            SIDE_LEFT:   if (a.left < b.left) s = SIDE_NONE;
            SIDE_RIGHT:  if (right_edge(a) > right_edge(b)) s = SIDE_NONE;
            SIDE_TOP:    if (a.top < b.top) s = SIDE_NONE;
            SIDE_BOTTOM: if (bottom_edge(a) > bottom_edge(b)) s = SIDE_NONE;
            default: ;
        endcase
        return s;
    endfunction

    // A still box takes the mirror of what a differently moving partner sees
    function automatic t_side contact_side(input t_box_fields a, input t_box_fields b);
        if (a.vx == 0 && a.vy == 0 && (a.vx != b.vx || a.vy != b.vy))
            return reverse_side(mover_side(b, a));
        return mover_side(a, b);
    endfunction

    // Work out every report of the closed frame, then empty the store
    function automatic void predict_frame();
        t_side_report           frame [$];
        t_side_report           rpt;
        logic [MAX_BOXES-1:0]   touched;
        t_side                  s;
        touched = '0;
        for (int i = 0; i < boxes_held; i++) begin
            for (int j = i + 1; j < boxes_held; j++) begin
                if (span_overlap(held_boxes[i].left, right_edge(held_boxes[i]),
                                 held_boxes[j].left, right_edge(held_boxes[j])) > 0 &&
                    span_overlap(held_boxes[i].top, bottom_edge(held_boxes[i]),
                                 held_boxes[j].top, bottom_edge(held_boxes[j])) > 0) begin
                    s     = contact_side(held_boxes[i], held_boxes[j]);
                    rpt   = '{idx: IDX_W'(i), side: s, last: 1'b0};
                    frame = {frame, rpt};
                    rpt   = '{idx: IDX_W'(j), side: reverse_side(s), last: 1'b0};
                    frame = {frame, rpt};
                    touched[i] = 1'b1;
                    touched[j] = 1'b1;
                end
            end
        end
        for (int i = 0; i < boxes_held; i++) begin
            if (!touched[i]) begin
                rpt   = '{idx: IDX_W'(i), side: SIDE_NONE, last: 1'b0};
                frame = {frame, rpt};
            end
        end
        frame[frame.size() - 1].last = 1'b1;
        pending_reports = {pending_reports, frame};
        boxes_held = 0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_box_fields make_box(input int left, input int top, input int w,
                                             input int h, input int vx, input int vy);
        t_box_fields b;
        b.left   = left[POS_W-1:0];
        b.top    = top[POS_W-1:0];
        b.width  = w[SIZE_W-1:0];
        b.height = h[SIZE_W-1:0];
        b.vx     = vx[VEL_W-1:0];
        b.vy     = vy[VEL_W-1:0];
        return b;
    endfunction

    // Speeds lean toward zero and small values so all side rules get hit
    function automatic int pick_speed();
        unique case ($urandom_range(0, 5))
            0, 1:    return 0;
            2:       return int'($urandom_range(1, 512));
            3:       return -int'($urandom_range(1, 512));
            default: return int'($urandom);
        endcase
    endfunction

    // Mostly boxes crowded near the origin, now and then any value at all
    function automatic t_box_fields random_box(input t_box_fields prev);
        t_box_fields b;
        if ($urandom_range(0, 7) == 0) begin
            b = make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            b = make_box(int'($urandom_range(0, 4096)) - 2048,
                         int'($urandom_range(0, 4096)) - 2048,
                         ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2048),
                         ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2048),
                         pick_speed(), pick_speed());
            // share the previous velocity to hit the same-motion case
            if ($urandom_range(0, 4) == 0) begin
                b.vx = prev.vx;
                b.vy = prev.vy;
            end
        end
        return b;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Send one box request and update the predictor once it is taken
    task automatic send_box(input t_box_fields b, input bit final_box);
        int gap;
        gap = src_pace ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {2'b00, b};
        s_axis_tlast  <= final_box;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (boxes_held < MAX_BOXES) begin
            held_boxes[boxes_held] = b;
            boxes_held++;
        end
        if (final_box) predict_frame();
        boxes_sent++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Frame of one box at the field extremes: reports none only
    task automatic test_lone_box();
        src_pace  = 1'b0;
        sink_pace = 1'b0;
        send_box(make_box(-8388608, 8388607, 8388607, 8388607, -32768, 32767), 1'b1);
    endtask

    // One pair per frame for each motion rule
    task automatic test_motion_sides();
        src_pace  = 1'b0;
        sink_pace = 1'b1;
        // moving right into a still box
        send_box(make_box(0, 0, 4096, 4096, 256, 0), 1'b0);
        send_box(make_box(2048, 512, 4096, 1024, 0, 0), 1'b1);
        // still box struck by one moving left
        send_box(make_box(0, 0, 4096, 4096, 0, 0), 1'b0);
        send_box(make_box(2048, 512, 4096, 1024, -256, 0), 1'b1);
        // falling straight down
        send_box(make_box(0, 0, 2048, 2048, 0, 512), 1'b0);
        send_box(make_box(-512, 1024, 4096, 2048, 0, 0), 1'b1);
        // rising with a wide overlap
        send_box(make_box(0, 1024, 4096, 2048, 256, -512), 1'b0);
        send_box(make_box(512, 0, 2048, 1536, 0, 0), 1'b1);
        // diagonal with a tall overlap: edge test rejects the side
        send_box(make_box(0, 0, 1024, 4096, -256, 256), 1'b0);
        send_box(make_box(512, 256, 2048, 2048, 128, 128), 1'b1);
        // both boxes still
        send_box(make_box(1024, 0, 2048, 2048, 0, 0), 1'b0);
        send_box(make_box(0, 512, 2048, 2048, 0, 0), 1'b1);
    endtask

    // Boxes with no width or no height touch nothing
    task automatic test_zero_size();
        src_pace  = 1'b1;
        sink_pace = 1'b0;
        send_box(make_box(0, 0, 0, 4096, 256, 0), 1'b0);
        send_box(make_box(0, 0, 4096, 0, 0, 256), 1'b0);
        send_box(make_box(-256, -256, 8192, 8192, 0, 0), 1'b1);
    endtask

    // Full store of mutually overlapping boxes, then one box too many closes it
    task automatic test_full_store();
        src_pace  = 1'b1;
        sink_pace = 1'b1;
        send_box(make_box(-8388608, -8388608, 8388607, 8388607, 32767, -32768), 1'b0);
        for (int k = 1; k < MAX_BOXES; k++)
            send_box(make_box(-768 + 16 * k, -768 + 32 * k, 1536, 1536,
                              (k % 3 - 1) * 300, ((k / 2) % 3 - 1) * 200), 1'b0);
        send_box(make_box(8388607, -8388608, 0, 8388607, -32768, 32767), 1'b1);
    endtask

    // Random frames, mostly within capacity, with per-frame pacing
    task automatic test_random_frames(input int item_goal);
        int          first;
        int          frame_len;
        t_box_fields b;
        first = boxes_sent;
        b = make_box(0, 0, 256, 256, 0, 0);
        while (boxes_sent - first < item_goal) begin
            frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_BOXES + 1, 11)
                                                    : $urandom_range(1, MAX_BOXES);
            src_pace  = $urandom_range(0, 1);
            sink_pace = $urandom_range(0, 1);
            for (int k = 0; k < frame_len; k++) begin
                b = random_box(b);
                send_box(b, k == frame_len - 1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Report checker with random back-pressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : report_check
        t_side_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected report: box %0d side %0d last %0b",
                                          m_axis_tdata[IDX_W-1:0],
                                          m_axis_tdata[IDX_W+2:IDX_W], m_axis_tlast));
            end else begin
                want = pending_reports.pop_front();
                if (m_axis_tdata[IDX_W-1:0] !== want.idx)
                    report_mismatch($sformatf("box index %0d, expected %0d",
                                              m_axis_tdata[IDX_W-1:0], want.idx));
                if (m_axis_tdata[IDX_W+2:IDX_W] !== want.side)
                    report_mismatch($sformatf("box %0d side %0d, expected %0d", want.idx,
                                              m_axis_tdata[IDX_W+2:IDX_W], want.side));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("box %0d end of report %0b, expected %0b",
                                              want.idx, m_axis_tlast, want.last));
            end
            sink_hold = sink_pace ? $urandom_range(0, MAX_GAP) : 0;
        end else if (m_axis_tvalid && sink_hold > 0) begin
            sink_hold--;
        end
        m_axis_tready <= (sink_hold == 0);
    end

    // Stop the run when no request moves on either side for too long
    always @(posedge i_clk) begin : stall_watch
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** aabb_pair_collision_sides: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_lone_box();
        test_motion_sides();
        test_zero_size();
        test_full_store();
        test_random_frames(RANDOM_ITEMS);

        // drain every owed report, then watch for strays
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("** aabb_pair_collision_sides: PASSED **");
        end else begin
            $display("** aabb_pair_collision_sides: FAILED **");
        end
        $finish;
    end

endmodule
